// ===== hdl/tod_pkg.sv =====
package tod_pkg;

  // field widths of one time of day
  localparam int unsigned HoursW = 5;
  localparam int unsigned MinsW  = 6;
  localparam int unsigned SecsW  = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  localparam logic [HoursW-1:0] HoursMax = 5'd23;
  localparam logic [MinsW-1:0]  MinsMax  = 6'd59;
  localparam logic [SecsW-1:0]  SecsMax  = 6'd59;
  localparam logic [SecsW-1:0]  SecsPerMin  = 6'd60;
  localparam logic [HoursW-1:0] HoursPerDay = 5'd24;

  // operation codes of an input beat
  typedef enum logic [1:0] {
    OP_REPORT  = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_HOURS   = 2'd0,
    CFG_START_MINUTES = 2'd1,
    CFG_START_SECONDS = 2'd2
  } cfg_idx_e;

  // hh:mm:ss, hours in the top bits so that a plain compare orders times
  typedef struct packed {
    logic [HoursW-1:0] hours;
    logic [MinsW-1:0]  minutes;
    logic [SecsW-1:0]  seconds;
  } hms_t;

  typedef struct packed {
    hms_t now;
    hms_t left;
    hms_t diff;
    logic later;
  } result_t;

  localparam hms_t DayEnd = '{hours: HoursPerDay, minutes: '0, seconds: '0};
  localparam hms_t Midnight = '{hours: '0, minutes: '0, seconds: '0};

  // clamp a time to its legal range
  function automatic hms_t hms_sat(hms_t t);
    hms_t r;
    r.hours   = (t.hours > HoursMax) ? HoursMax : t.hours;
    r.minutes = (t.minutes > MinsMax) ? MinsMax : t.minutes;
    r.seconds = (t.seconds > SecsMax) ? SecsMax : t.seconds;
    return r;
  endfunction

  // one second forward with wrap at 23:59:59
  function automatic hms_t hms_tick(hms_t t);
    hms_t r;
    r = t;
    if (t.seconds >= SecsMax) begin
      r.seconds = '0;
      if (t.minutes >= MinsMax) begin
        r.minutes = '0;
        r.hours   = (t.hours >= HoursMax) ? '0 : t.hours + 5'd1;
      end else begin
        r.minutes = t.minutes + 6'd1;
      end
    end else begin
      r.seconds = t.seconds + 6'd1;
    end
    return r;
  endfunction

  // mixed-radix a - b, a not below b
  function automatic hms_t hms_sub(hms_t a, hms_t b);
    logic [SecsW:0] sd;
    logic [MinsW:0] md;
    hms_t r;
    sd = {1'b0, a.seconds} - {1'b0, b.seconds};
    r.seconds = sd[SecsW] ? (sd[SecsW-1:0] + SecsPerMin) : sd[SecsW-1:0];
    md = {1'b0, a.minutes} - {1'b0, b.minutes} - {{MinsW{1'b0}}, sd[SecsW]};
    r.minutes = md[MinsW] ? (md[MinsW-1:0] + SecsPerMin) : md[MinsW-1:0];
    r.hours = a.hours - b.hours - {{(HoursW-1){1'b0}}, md[MinsW]};
    return r;
  endfunction

endpackage

// ===== hdl/time_of_day_clock_core.sv =====
// 24-hour hh:mm:ss clock. Each input beat reports the time, advances it by one
// second or reloads it from the start registers, and always yields one result
// beat: the time after the operation, the time left to midnight (zero at
// midnight), the absolute difference to the compared time and a later flag.
// One beat is taken every cycle unless in_stall_o is high; a result passes the
// input register, then the result register, before it appears on the outputs,
// and the input register can still take one beat while a finished result is
// stalled at the output.
// Compared times and start values above range are clamped to 23 or 59.
// Start registers must be written only while the block is idle (not enforced).
module time_of_day_clock_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [tod_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tod_pkg::CfgDataW-1:0]  cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [tod_pkg::HoursW-1:0]    other_hours_i,
  input  logic [tod_pkg::MinsW-1:0]     other_minutes_i,
  input  logic [tod_pkg::SecsW-1:0]     other_seconds_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tod_pkg::HoursW-1:0]    now_hours_o,
  output logic [tod_pkg::MinsW-1:0]     now_minutes_o,
  output logic [tod_pkg::SecsW-1:0]     now_seconds_o,
  output logic [tod_pkg::HoursW-1:0]    left_hours_o,
  output logic [tod_pkg::MinsW-1:0]     left_minutes_o,
  output logic [tod_pkg::SecsW-1:0]     left_seconds_o,
  output logic [tod_pkg::HoursW-1:0]    diff_hours_o,
  output logic [tod_pkg::MinsW-1:0]     diff_minutes_o,
  output logic [tod_pkg::SecsW-1:0]     diff_seconds_o,
  output logic                          is_later_o
);
  import tod_pkg::*;

  hms_t    start_q;
  hms_t    clock_q, clock_d;
  logic    in_valid_q, in_valid_d;
  logic [1:0] op_q;
  hms_t    other_q;
  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;
  logic    in_accept, advance;

  // handshake control
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // clock update for the beat in the input register
  always_comb begin
    clock_d = clock_q;
    case (op_q)
      OP_TICK:    clock_d = hms_tick(clock_q);
      OP_RESTART: clock_d = hms_sat(start_q);
      default:    clock_d = clock_q;
    endcase
  end

  // result fields from the updated time
  always_comb begin
    res_d.now   = clock_d;
    res_d.left  = (clock_d == Midnight) ? Midnight : hms_sub(DayEnd, clock_d);
    res_d.later = clock_d > other_q;
    res_d.diff  = res_d.later ? hms_sub(clock_d, other_q) : hms_sub(other_q, clock_d);
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= Midnight;
      clock_q     <= Midnight;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        clock_q <= clock_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_START_HOURS:   start_q.hours   <= cfg_data_i[HoursW-1:0];
          CFG_START_MINUTES: start_q.minutes <= cfg_data_i[MinsW-1:0];
          CFG_START_SECONDS: start_q.seconds <= cfg_data_i[SecsW-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= op_i;
      other_q <= hms_sat('{hours: other_hours_i, minutes: other_minutes_i,
                          seconds: other_seconds_i});
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign now_hours_o    = res_q.now.hours;
  assign now_minutes_o  = res_q.now.minutes;
  assign now_seconds_o  = res_q.now.seconds;
  assign left_hours_o   = res_q.left.hours;
  assign left_minutes_o = res_q.left.minutes;
  assign left_seconds_o = res_q.left.seconds;
  assign diff_hours_o   = res_q.diff.hours;
  assign diff_minutes_o = res_q.diff.minutes;
  assign diff_seconds_o = res_q.diff.seconds;
  assign is_later_o     = res_q.later;

  // clock state always holds a legal time
  a_clock_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clock_q.hours <= HoursMax && clock_q.minutes <= MinsMax && clock_q.seconds <= SecsMax)
    else $error("clock state out of range");

  // a pending result shows the current clock state
  a_now_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_q.now == clock_q)
    else $error("result time differs from clock state");

  // later means a nonzero difference
  a_later_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.later |-> res_q.diff != Midnight)
    else $error("later flag with zero difference");

  // an empty input register never stalls the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  // a beat in the input register moves on once the output frees up
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_valid_q |=> out_valid_q)
    else $error("input beat did not reach the result register");

endmodule
